### src/sttok_pkg.sv
// ----------------------------------------------------------------------------
// sttok_pkg
// Shared types and character constants for the source text tokeniser.
// ----------------------------------------------------------------------------
package sttok_pkg;

  // Token kinds, as carried on the item that closes a token.
  typedef enum logic [4:0] {
    K_EOF       = 5'd0,
    K_ILLEGAL   = 5'd1,
    K_IDENT     = 5'd2,
    K_INT       = 5'd3,
    K_FLOAT     = 5'd4,
    K_STR       = 5'd5,
    K_ASSIGN    = 5'd6,
    K_PLUS      = 5'd7,
    K_MINUS     = 5'd8,
    K_BANG      = 5'd9,
    K_MUL       = 5'd10,
    K_DIV       = 5'd11,
    K_LT        = 5'd12,
    K_GT        = 5'd13,
    K_EQ        = 5'd14,
    K_NOT_EQ    = 5'd15,
    K_COMMA     = 5'd16,
    K_SEMICOLON = 5'd17,
    K_LPAREN    = 5'd18,
    K_RPAREN    = 5'd19,
    K_LBRACE    = 5'd20,
    K_RBRACE    = 5'd21
  } kind_t;

  // Scanner modes, one-hot.
  typedef enum logic [5:0] {
    M_IDLE  = 6'b000001,
    M_IDENT = 6'b000010,
    M_NUM   = 6'b000100,
    M_STR   = 6'b001000,
    M_EQ    = 6'b010000,
    M_BANG  = 6'b100000
  } mode_t;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQUALS = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_UC_A   = 8'h41;
  localparam logic [7:0] CH_UC_Z   = 8'h5A;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LC_A   = 8'h61;
  localparam logic [7:0] CH_LC_Z   = 8'h7A;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  // Default queue depth: three or more keeps one item a cycle if not stalled.
  localparam int unsigned QUEUE_DEPTH = 3;

  // One result item.
  typedef struct packed {
    logic [4:0] kind;
    logic [7:0] lit_char;
    logic       has_char;
    logic       token_last;
  } item_t;

  // What one accepted byte pushes into the result queue.
  typedef struct packed {
    logic [1:0] cnt;
    item_t      item0;
    item_t      item1;
  } push_t;

endpackage

### src/sttok_if.sv
// ----------------------------------------------------------------------------
// sttok_in_if / sttok_out_if
// Valid/ready channels for source bytes and for result items.
// ----------------------------------------------------------------------------
interface sttok_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink (input valid, input ch, output ready);
endinterface

interface sttok_out_if;
  logic       valid;
  logic       ready;
  logic [4:0] kind;
  logic [7:0] lit_char;
  logic       has_char;
  logic       token_last;

  modport source (output valid, output kind, output lit_char, output has_char,
                  output token_last, input ready);
  modport sink (input valid, input kind, input lit_char, input has_char,
                input token_last, output ready);
endinterface

### src/sttok_scan.sv
// ----------------------------------------------------------------------------
// sttok_scan
// Scanner state and the next-item logic for one source byte.
// ----------------------------------------------------------------------------
module sttok_scan
  import sttok_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       fire,
  input  logic [7:0] ch,
  output push_t      push
);

  mode_t      mode_r, mode_nxt;
  logic [1:0] dots_r, dots_nxt;
  logic       pdot_r, pdot_nxt;

  logic       is_letter, is_digit, is_space;
  logic       do_start;
  logic       pre_v, post_v;
  item_t      pre_item, post_item;
  logic       st_v;
  item_t      st_item;
  mode_t      st_mode;
  logic [4:0] single_kind;

  always_comb begin
    is_letter = ((ch >= CH_LC_A) && (ch <= CH_LC_Z)) ||
                ((ch >= CH_UC_A) && (ch <= CH_UC_Z)) || (ch == CH_UNDER);
    is_digit  = (ch >= CH_ZERO) && (ch <= CH_NINE);
    is_space  = (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_CR) || (ch == CH_LF);
  end

  always_comb begin
    case (ch)
      CH_PLUS:   single_kind = K_PLUS;
      CH_MINUS:  single_kind = K_MINUS;
      CH_STAR:   single_kind = K_MUL;
      CH_SLASH:  single_kind = K_DIV;
      CH_LT:     single_kind = K_LT;
      CH_GT:     single_kind = K_GT;
      CH_COMMA:  single_kind = K_COMMA;
      CH_SEMI:   single_kind = K_SEMICOLON;
      CH_LPAREN: single_kind = K_LPAREN;
      CH_RPAREN: single_kind = K_RPAREN;
      CH_LBRACE: single_kind = K_LBRACE;
      CH_RBRACE: single_kind = K_RBRACE;
      default:   single_kind = K_ILLEGAL;
    endcase
  end

  // Handling of a byte that arrives between tokens.
  always_comb begin
    st_v    = 1'b1;
    st_mode = M_IDLE;
    st_item = '{kind: K_EOF, lit_char: ch, has_char: 1'b1, token_last: 1'b0};
    if (is_space) begin
      st_v = 1'b0;
    end else if (ch == CH_NUL) begin
      st_item = '{kind: K_EOF, lit_char: 8'h00, has_char: 1'b0, token_last: 1'b1};
    end else if (ch == CH_EQUALS) begin
      st_mode = M_EQ;
    end else if (ch == CH_BANG) begin
      st_mode = M_BANG;
    end else if (ch == CH_QUOTE) begin
      st_v    = 1'b0;
      st_mode = M_STR;
    end else if (is_letter) begin
      st_mode = M_IDENT;
    end else if (is_digit) begin
      st_mode = M_NUM;
    end else begin
      st_item.kind       = single_kind;
      st_item.token_last = 1'b1;
    end
  end

  always_comb begin
    mode_nxt  = mode_r;
    dots_nxt  = dots_r;
    pdot_nxt  = pdot_r;
    do_start  = 1'b0;
    pre_v     = 1'b0;
    pre_item  = '{kind: K_EOF, lit_char: 8'h00, has_char: 1'b0, token_last: 1'b1};
    post_v    = 1'b0;
    post_item = '{kind: K_EOF, lit_char: 8'h00, has_char: 1'b0, token_last: 1'b1};
    case (mode_r)
      M_IDENT: begin
        if (is_letter) begin
          pre_v    = 1'b1;
          pre_item = '{kind: K_EOF, lit_char: ch, has_char: 1'b1, token_last: 1'b0};
        end else begin
          pre_v         = 1'b1;
          pre_item.kind = K_IDENT;
          do_start      = 1'b1;
        end
      end
      M_NUM: begin
        if (is_digit || (ch == CH_DOT)) begin
          pre_v    = 1'b1;
          pre_item = '{kind: K_EOF, lit_char: ch, has_char: 1'b1, token_last: 1'b0};
          pdot_nxt = (ch == CH_DOT);
          if ((ch == CH_DOT) && (dots_r != 2'd2)) begin
            dots_nxt = dots_r + 2'd1;
          end
        end else begin
          pre_v = 1'b1;
          if (pdot_r || (dots_r == 2'd2)) begin
            pre_item.kind = K_ILLEGAL;
          end else if (dots_r == 2'd1) begin
            pre_item.kind = K_FLOAT;
          end else begin
            pre_item.kind = K_INT;
          end
          dots_nxt = 2'd0;
          pdot_nxt = 1'b0;
          do_start = 1'b1;
        end
      end
      M_STR: begin
        pre_v = 1'b1;
        if (ch == CH_QUOTE) begin
          pre_item.kind = K_STR;
          mode_nxt      = M_IDLE;
        end else if (ch == CH_NUL) begin
          // End of input inside a string closes it and reports eof as well.
          pre_item.kind = K_STR;
          post_v        = 1'b1;
          mode_nxt      = M_IDLE;
        end else begin
          pre_item = '{kind: K_EOF, lit_char: ch, has_char: 1'b1, token_last: 1'b0};
        end
      end
      M_EQ, M_BANG: begin
        pre_v = 1'b1;
        if (ch == CH_EQUALS) begin
          pre_item = '{kind: (mode_r == M_EQ) ? K_EQ : K_NOT_EQ, lit_char: ch,
                       has_char: 1'b1, token_last: 1'b1};
          mode_nxt = M_IDLE;
        end else begin
          pre_item.kind = (mode_r == M_EQ) ? K_ASSIGN : K_BANG;
          do_start      = 1'b1;
        end
      end
      default: begin
        do_start = 1'b1;
      end
    endcase

    if (do_start) begin
      mode_nxt  = st_mode;
      post_v    = st_v;
      post_item = st_item;
      if (st_mode == M_NUM) begin
        dots_nxt = 2'd0;
        pdot_nxt = 1'b0;
      end
    end

    push.cnt   = {1'b0, pre_v} + {1'b0, post_v};
    push.item0 = pre_v ? pre_item : post_item;
    push.item1 = post_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
      dots_r <= 2'd0;
      pdot_r <= 1'b0;
    end else if (fire) begin
      mode_r <= mode_nxt;
      dots_r <= dots_nxt;
      pdot_r <= pdot_nxt;
    end
  end

endmodule

### src/sttok_outq.sv
// ----------------------------------------------------------------------------
// sttok_outq
// Result queue: up to two items in a cycle if room, one out a cycle if ready.
// ----------------------------------------------------------------------------
module sttok_outq
  import sttok_pkg::*;
#(
  parameter int unsigned Depth = QUEUE_DEPTH
)
(
  input  logic  clk,
  input  logic  rst_n,
  input  push_t push,
  input  logic  push_en,
  output logic  room,
  output logic  head_valid,
  output item_t head,
  input  logic  pop
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  item_t             entries_r [Depth];
  logic [PtrW-1:0]   wr_r, wr_nxt, rd_r, rd_nxt, wr_p1;
  logic [CntW-1:0]   count_r, count_nxt;
  logic [1:0]        n_push;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    logic [PtrW-1:0] r;
    if (p == PtrW'(Depth - 1)) begin
      r = '0;
    end else begin
      r = p + PtrW'(1);
    end
    return r;
  endfunction

  assign n_push     = push_en ? push.cnt : 2'd0;
  assign wr_p1      = ptr_inc(wr_r);
  // Room for the largest push, judged on the registered fill only.
  assign room       = (count_r <= CntW'(Depth - 2));
  assign head_valid = (count_r != '0);
  assign head       = entries_r[rd_r];

  always_comb begin
    case (n_push)
      2'd1:    wr_nxt = wr_p1;
      2'd2:    wr_nxt = ptr_inc(wr_p1);
      default: wr_nxt = wr_r;
    endcase
    rd_nxt    = pop ? ptr_inc(rd_r) : rd_r;
    count_nxt = count_r + CntW'(n_push) - CntW'(pop);
  end

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      entries_r[wr_r] <= push.item0;
    end
    if (n_push == 2'd2) begin
      entries_r[wr_p1] <= push.item1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      count_r <= '0;
    end else begin
      wr_r    <= wr_nxt;
      rd_r    <= rd_nxt;
      count_r <= count_nxt;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntW'(Depth))
    else $error("result queue over-filled");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("result queue popped while empty");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    (n_push != 2'd0) |-> room)
    else $error("result queue pushed without room");

  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (wr_r == rd_r))
    else $error("result queue pointers disagree with fill count");

endmodule

### src/source_text_tokenizer_core.sv
// ----------------------------------------------------------------------------
// source_text_tokenizer_core
// Streaming tokeniser: one source byte in, a run of literal/kind items out.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake      Payload
//  in_ch_if  in         valid/ready    ch[7:0]
//  out_tok_if out       valid/ready    kind[4:0] lit_char[7:0] has_char token_last
//
// A byte is scanned in the cycle it is accepted; its zero to two items are
// written straight into the result queue and the first can leave next cycle.
// With a three-entry queue and a ready receiver one byte is taken every cycle
// while each byte yields at most one item; a byte yielding two holds off the next.
// Reset is synchronous and returns the scanner to between tokens, queue empty.
// A stalled result side drops in_ch_if.ready once two items no longer fit.
// ----------------------------------------------------------------------------
module source_text_tokenizer_core
  import sttok_pkg::*;
#(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
)
(
  input  logic               clk,
  input  logic               rst_n,
  sttok_in_if.sink           in_ch_if,
  sttok_out_if.source        out_tok_if
);

  logic  in_fire, out_fire, room, head_valid;
  push_t push;
  item_t head;

  assign in_ch_if.ready = room;
  assign in_fire        = in_ch_if.valid && room;
  assign out_fire       = head_valid && out_tok_if.ready;

  sttok_scan u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (in_fire),
    .ch    (in_ch_if.ch),
    .push  (push)
  );

  sttok_outq #(
    .Depth (QueueDepth)
  ) u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_en    (in_fire),
    .room       (room),
    .head_valid (head_valid),
    .head       (head),
    .pop        (out_fire)
  );

  assign out_tok_if.valid      = head_valid;
  assign out_tok_if.kind       = head.kind;
  assign out_tok_if.lit_char   = head.lit_char;
  assign out_tok_if.has_char   = head.has_char;
  assign out_tok_if.token_last = head.token_last;

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Streams source bytes into the tokeniser and checks every result item.
// A short table of hand-picked bytes comes first, then randomly built text:
// mostly well-formed identifiers, numbers, strings and operators, with noise.
// A scanner kept in step with the accepted bytes works out the items due.
// ----------------------------------------------------------------------------
module testbench;
  import sttok_pkg::*;

  localparam int unsigned CLK_HALF     = 2;
  localparam int unsigned RESET_CYCLES = 10;
  localparam int unsigned RANDOM_BYTES = 900;
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int          SCANNED      = -1;

  localparam logic [7:0] OP_CHARS [14] = '{
    CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_LT, CH_GT, CH_COMMA,
    CH_SEMI, CH_LPAREN, CH_RPAREN, CH_LBRACE, CH_RBRACE, CH_EQUALS, CH_BANG
  };

  // One source byte; where typed is set, e0/e1 are the items written out by hand.
  typedef struct {
    logic [7:0] ch;
    bit         typed;
    int         n_typed;
    item_t      e0;
    item_t      e1;
  } stim_row_t;

  typedef enum {STALL_NONE, STALL_RANDOM, STALL_PERIODIC, STALL_LONG} stall_style_t;

  logic clk = 1'b0;
  logic rst_n;

  sttok_in_if  ch_bus ();
  sttok_out_if tok_bus ();

  source_text_tokenizer_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch_if   (ch_bus),
    .out_tok_if (tok_bus)
  );

  always #(CLK_HALF) clk = ~clk;

  mode_t       scan_mode;
  logic [1:0]  scan_dots;
  logic        scan_after_dot;
  item_t       items_due [$];
  stim_row_t   sent_rows [$];
  stim_row_t   text_rows [$];
  int unsigned fail_count;
  int unsigned cycle_count;

  function automatic item_t lit(logic [7:0] c);
    item_t it;
    it          = '0;
    it.lit_char = c;
    it.has_char = 1'b1;
    return it;
  endfunction

  function automatic item_t closer(kind_t k);
    item_t it;
    it            = '0;
    it.kind       = k;
    it.token_last = 1'b1;
    return it;
  endfunction

  function automatic item_t single(kind_t k, logic [7:0] c);
    item_t it;
    it          = closer(k);
    it.lit_char = c;
    it.has_char = 1'b1;
    return it;
  endfunction

  function automatic bit is_letter(logic [7:0] c);
    return (c >= CH_LC_A && c <= CH_LC_Z) || (c >= CH_UC_A && c <= CH_UC_Z) ||
           c == CH_UNDER;
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic kind_t single_kind(logic [7:0] c);
    case (c)
      CH_PLUS:   return K_PLUS;
      CH_MINUS:  return K_MINUS;
      CH_STAR:   return K_MUL;
      CH_SLASH:  return K_DIV;
      CH_LT:     return K_LT;
      CH_GT:     return K_GT;
      CH_COMMA:  return K_COMMA;
      CH_SEMI:   return K_SEMICOLON;
      CH_LPAREN: return K_LPAREN;
      CH_RPAREN: return K_RPAREN;
      CH_LBRACE: return K_LBRACE;
      CH_RBRACE: return K_RBRACE;
      default:   return K_ILLEGAL;
    endcase
  endfunction

  // A byte seen between tokens.
  function automatic void open_token(logic [7:0] c);
    scan_mode = M_IDLE;
    if (c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF) begin
      return;
    end else if (c == CH_NUL) begin
      items_due.push_back(closer(K_EOF));
    end else if (c == CH_EQUALS) begin
      scan_mode = M_EQ;
      items_due.push_back(lit(c));
    end else if (c == CH_BANG) begin
      scan_mode = M_BANG;
      items_due.push_back(lit(c));
    end else if (c == CH_QUOTE) begin
      scan_mode = M_STR;
    end else if (is_letter(c)) begin
      scan_mode = M_IDENT;
      items_due.push_back(lit(c));
    end else if (is_digit(c)) begin
      scan_mode      = M_NUM;
      scan_dots      = 2'd0;
      scan_after_dot = 1'b0;
      items_due.push_back(lit(c));
    end else begin
      items_due.push_back(single(single_kind(c), c));
    end
  endfunction

  function automatic void scan_byte(logic [7:0] c);
    kind_t k;
    case (scan_mode)
      M_IDENT: begin
        if (is_letter(c)) begin
          items_due.push_back(lit(c));
        end else begin
          items_due.push_back(closer(K_IDENT));
          open_token(c);
        end
      end
      M_NUM: begin
        if (is_digit(c)) begin
          scan_after_dot = 1'b0;
          items_due.push_back(lit(c));
        end else if (c == CH_DOT) begin
          scan_after_dot = 1'b1;
          if (scan_dots < 2'd2) scan_dots = scan_dots + 2'd1;
          items_due.push_back(lit(c));
        end else begin
          if (scan_after_dot || scan_dots >= 2'd2) k = K_ILLEGAL;
          else if (scan_dots == 2'd1) k = K_FLOAT;
          else k = K_INT;
          scan_dots      = 2'd0;
          scan_after_dot = 1'b0;
          items_due.push_back(closer(k));
          open_token(c);
        end
      end
      M_STR: begin
        if (c == CH_QUOTE) begin
          scan_mode = M_IDLE;
          items_due.push_back(closer(K_STR));
        end else if (c == CH_NUL) begin
          // End of input inside a string closes it and reports eof as well.
          scan_mode = M_IDLE;
          items_due.push_back(closer(K_STR));
          items_due.push_back(closer(K_EOF));
        end else begin
          items_due.push_back(lit(c));
        end
      end
      M_EQ, M_BANG: begin
        if (c == CH_EQUALS) begin
          k = (scan_mode == M_EQ) ? K_EQ : K_NOT_EQ;
          scan_mode = M_IDLE;
          items_due.push_back(single(k, c));
        end else begin
          k = (scan_mode == M_EQ) ? K_ASSIGN : K_BANG;
          items_due.push_back(closer(k));
          open_token(c);
        end
      end
      default: open_token(c);
    endcase
  endfunction

  task automatic report_mismatch(string msg);
    fail_count++;
    $display("[%0t] MISMATCH: %s", $time, msg);
  endtask

  task automatic add_row(logic [7:0] c, int n = SCANNED, item_t e0 = '0, item_t e1 = '0);
    stim_row_t row;
    row.ch      = c;
    row.typed   = (n != SCANNED);
    row.n_typed = n;
    row.e0      = e0;
    row.e1      = e1;
    text_rows.push_back(row);
  endtask

  task automatic load_directed();
    add_row(CH_NUL,    1, closer(K_EOF));
    add_row(8'hFF,     1, single(K_ILLEGAL, 8'hFF));
    add_row(CH_EQUALS, 1, lit(CH_EQUALS));
    add_row(CH_EQUALS, 1, single(K_EQ, CH_EQUALS));
    add_row(CH_BANG,   1, lit(CH_BANG));
    add_row(CH_LC_A,   2, closer(K_BANG), lit(CH_LC_A));
    add_row(CH_UNDER,  1, lit(CH_UNDER));
    add_row(CH_UC_Z,   1, lit(CH_UC_Z));
    add_row(CH_SLASH,  2, closer(K_IDENT), single(K_DIV, CH_SLASH));
    add_row(CH_NINE);
    add_row(CH_DOT);
    add_row(CH_DOT);
    add_row(CH_PLUS,   2, closer(K_ILLEGAL), single(K_PLUS, CH_PLUS));
    add_row(CH_ZERO);
    add_row(CH_DOT);
    add_row(CH_MINUS,  2, closer(K_ILLEGAL), single(K_MINUS, CH_MINUS));
    add_row("1");
    add_row(CH_DOT);
    add_row("5");
    add_row(CH_CR,     1, closer(K_FLOAT));
    add_row(CH_BANG);
    add_row(CH_EQUALS, 1, single(K_NOT_EQ, CH_EQUALS));
    add_row(CH_QUOTE,  0);
    add_row(CH_SPACE);
    add_row(8'h80);
    add_row(CH_NUL,    2, closer(K_STR), closer(K_EOF));
    add_row("7");
    add_row(CH_STAR,   2, closer(K_INT), single(K_MUL, CH_STAR));
    add_row(CH_EQUALS);
    add_row(CH_TAB,    1, closer(K_ASSIGN));
    add_row(CH_LT);
    add_row(CH_GT);
    add_row(CH_COMMA);
    add_row(CH_SEMI);
    add_row(CH_LPAREN);
    add_row(CH_RPAREN);
    add_row(CH_LBRACE);
    add_row(CH_LF,     0);
    add_row(CH_RBRACE);
    add_row(CH_NUL,    1, closer(K_EOF));
  endtask

  function automatic logic [7:0] random_letter();
    int unsigned r;
    r = $urandom_range(0, 52);
    if (r < 26) return CH_LC_A + 8'(r);
    if (r < 52) return CH_UC_A + 8'(r - 26);
    return CH_UNDER;
  endfunction

  function automatic logic [7:0] random_space();
    case ($urandom_range(0, 3))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      2:       return CH_CR;
      default: return CH_LF;
    endcase
  endfunction

  task automatic add_digits(int unsigned n);
    repeat (n) add_row(CH_ZERO + 8'($urandom_range(0, 9)));
  endtask

  task automatic build_random(int unsigned count);
    int unsigned target;
    int unsigned pick;
    int unsigned shape;
    logic [7:0]  c;
    target = text_rows.size() + count;
    while (text_rows.size() < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        repeat ($urandom_range(1, 8)) add_row(random_letter());
      end else if (pick < 45) begin
        // Mostly int and float; the rest end in a dot or carry several dots.
        shape = $urandom_range(0, 9);
        add_digits($urandom_range(1, 5));
        if (shape >= 4) begin
          add_row(CH_DOT);
          if (shape != 8) add_digits($urandom_range(1, 4));
          if (shape == 9) begin
            add_row(CH_DOT);
            add_digits($urandom_range(0, 3));
          end
        end
      end else if (pick < 57) begin
        add_row(CH_QUOTE);
        repeat ($urandom_range(0, 8)) begin
          c = 8'($urandom_range(1, 255));
          add_row((c == CH_QUOTE) ? CH_LC_A : c);
        end
        add_row(($urandom_range(0, 7) == 0) ? CH_NUL : CH_QUOTE);
      end else if (pick < 80) begin
        c = OP_CHARS[$urandom_range(0, 13)];
        add_row(c);
        if ((c == CH_EQUALS || c == CH_BANG) && $urandom_range(0, 1) == 1) add_row(CH_EQUALS);
      end else if (pick < 87) begin
        add_row(random_space());
      end else if (pick < 90) begin
        add_row(CH_NUL);
      end else begin
        add_row(8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 2) == 0) add_row(random_space());
    end
  endtask

  task automatic send_row(stim_row_t row);
    @(negedge clk);
    ch_bus.valid <= 1'b1;
    ch_bus.ch    <= row.ch;
    sent_rows.push_back(row);
    do @(posedge clk); while (!ch_bus.ready);
  endtask

  task automatic pause_input(int unsigned n);
    repeat (n) begin
      @(negedge clk);
      ch_bus.valid <= 1'b0;
      ch_bus.ch    <= 8'($urandom);
    end
  endtask

  task automatic send_text();
    int unsigned burst;
    while (text_rows.size() != 0) begin
      burst = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 16);
      while (burst != 0 && text_rows.size() != 0) begin
        send_row(text_rows.pop_front());
        burst--;
      end
      if ($urandom_range(0, 3) != 0) pause_input($urandom_range(1, 8));
    end
  endtask

  task automatic wait_for_drain();
    pause_input(1);
    while (items_due.size() != 0) @(negedge clk);
  endtask

  // Receiver readiness, changing style after each randomly chosen span.
  always begin : stall_pattern
    stall_style_t style;
    int unsigned  span;
    int unsigned  pct;
    int unsigned  period;
    int unsigned  tick;
    style  = stall_style_t'($urandom_range(0, 3));
    span   = $urandom_range(16, 200);
    pct    = $urandom_range(10, 95);
    period = $urandom_range(2, 7);
    for (tick = 0; tick < span; tick++) begin
      @(negedge clk);
      case (style)
        STALL_NONE:     tok_bus.ready <= 1'b1;
        STALL_RANDOM:   tok_bus.ready <= ($urandom_range(0, 99) < pct);
        STALL_PERIODIC: tok_bus.ready <= ((tick % period) != 0);
        STALL_LONG:     tok_bus.ready <= ((tick % 32) >= 20);
        default:        tok_bus.ready <= 1'b1;
      endcase
    end
  end

  // Bytes are scanned before results are checked, so a same-edge result still lines up.
  always @(posedge clk) begin : scoreboard
    stim_row_t   row;
    int unsigned depth;
    item_t       want;
    if (rst_n) begin
      if (ch_bus.valid && ch_bus.ready) begin
        depth = items_due.size();
        scan_byte(ch_bus.ch);
        if (sent_rows.size() != 0) begin
          row = sent_rows.pop_front();
          if (row.typed) begin
            while (items_due.size() > depth) void'(items_due.pop_back());
            if (row.n_typed > 0) items_due.push_back(row.e0);
            if (row.n_typed > 1) items_due.push_back(row.e1);
          end
        end
      end
      if (tok_bus.valid && tok_bus.ready) begin
        if (items_due.size() == 0) begin
          report_mismatch($sformatf("transaction with nothing due: kind %0d char %02h",
                                    tok_bus.kind, tok_bus.lit_char));
        end else begin
          want = items_due.pop_front();
          if (tok_bus.kind != want.kind)
            report_mismatch($sformatf("kind %0d, expected %0d", tok_bus.kind, want.kind));
          if (tok_bus.lit_char != want.lit_char)
            report_mismatch($sformatf("lit_char %02h, expected %02h",
                                      tok_bus.lit_char, want.lit_char));
          if (tok_bus.has_char != want.has_char)
            report_mismatch($sformatf("has_char %0b, expected %0b",
                                      tok_bus.has_char, want.has_char));
          if (tok_bus.token_last != want.token_last)
            report_mismatch($sformatf("token_last %0b, expected %0b",
                                      tok_bus.token_last, want.token_last));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    scan_mode      = M_IDLE;
    scan_dots      = 2'd0;
    scan_after_dot = 1'b0;
    fail_count     = 0;
    cycle_count    = 0;
    rst_n          = 1'b0;
    ch_bus.valid   = 1'b0;
    ch_bus.ch      = CH_NUL;
    load_directed();
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    send_text();
    // The sender holds off here until every item due has been received.
    wait_for_drain();
    build_random(RANDOM_BYTES / 2);
    send_text();
    wait_for_drain();
    build_random(RANDOM_BYTES - RANDOM_BYTES / 2);
    send_text();
    wait_for_drain();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### files.f
src/sttok_pkg.sv
src/sttok_if.sv
src/sttok_scan.sv
src/sttok_outq.sv
src/source_text_tokenizer_core.sv
tb/testbench.sv
